// ===== src/dbpd_pkg.sv =====
// ----------------------------------------------------------------------------
// dbpd_pkg
// Shared types and constants of the delta block packed decoder.
// ----------------------------------------------------------------------------
package dbpd_pkg;

	localparam int unsigned MINI_SIZE_DEF = 32;
	localparam int unsigned BLOCK_LEN_DEF = 128;
	localparam int unsigned QUEUE_DEPTH   = 4;
	localparam int unsigned VALUE_W       = 32;

	typedef enum logic [1:0] {
		E_SET,
		E_ADD,
		E_ERR
	} entry_kind_t;

	typedef struct packed {
		entry_kind_t          kind;
		logic [VALUE_W-1:0]   data;
		logic                 run_last;
	} entry_t;

endpackage

// ===== src/dbpd_if.sv =====
// ----------------------------------------------------------------------------
// dbpd_if
// Byte and result channels of the delta block packed decoder.
// ----------------------------------------------------------------------------
interface dbpd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dbpd_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [dbpd_pkg::VALUE_W-1:0] value;
	logic                                run_last;
	logic                                error;

	modport source (output valid, output value, output run_last, output error, input ready);
	modport sink (input valid, input value, input run_last, input error, output ready);
endinterface

// ===== src/delta_block_packed_decoder.sv =====
// The first result of a byte passes the parser state, the word queue and the output register.
// Throughput: one result per cycle, set by the parser's one-word-per-cycle push, while the queue has room;
// a byte holds the parser until its results are pushed (MINI_SIZE of them for width zero).
// Bytes that yield no result are taken every cycle while the parser is idle.
// Reset: arst_n clears all control state at once; no clearing pass.
// ----------------------------------------------------------------------------
// delta_block_packed_decoder
// Top level: parser, word queue and value builder.
// ----------------------------------------------------------------------------
module delta_block_packed_decoder #(
	parameter int unsigned MINI_SIZE = dbpd_pkg::MINI_SIZE_DEF,
	parameter int unsigned BLOCK_LEN = dbpd_pkg::BLOCK_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	dbpd_byte_if.sink     byte_ch,
	dbpd_result_if.source result_ch
);

	logic             push, full, pop, empty;
	dbpd_pkg::entry_t push_entry, head;

	dbpd_front #(
		.MINI_SIZE(MINI_SIZE),
		.BLOCK_LEN(BLOCK_LEN)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.byte_ch(byte_ch),
		.push(push),
		.push_entry(push_entry),
		.full(full)
	);

	dbpd_fifo #(
		.DEPTH(dbpd_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.full(full),
		.pop(pop),
		.head(head),
		.empty(empty)
	);

	dbpd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.empty(empty),
		.pop(pop),
		.result_ch(result_ch)
	);

endmodule

// ===== src/dbpd_front.sv =====
// ----------------------------------------------------------------------------
// dbpd_front
// Stream parser: varints, bit widths and packed deltas, queued as words
// that set, add to or flag the running value.
// ----------------------------------------------------------------------------
module dbpd_front #(
	parameter int unsigned MINI_SIZE = dbpd_pkg::MINI_SIZE_DEF,
	parameter int unsigned BLOCK_LEN = dbpd_pkg::BLOCK_LEN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	dbpd_byte_if.sink           byte_ch,
	output logic                push,
	output dbpd_pkg::entry_t    push_entry,
	input  logic                full
);

	localparam int unsigned VW = $clog2(MINI_SIZE + 1);
	localparam int unsigned MB = ((BLOCK_LEN / MINI_SIZE) == 0) ? 1 : (BLOCK_LEN / MINI_SIZE);
	localparam int unsigned MW = $clog2(MB + 1);

	typedef enum logic {ST_IDLE, ST_RUN} state_t;
	typedef enum logic [1:0] {J_SET, J_ZERO, J_ERR, J_PACK} job_t;
	typedef enum logic [1:0] {P_FIRST, P_MIN, P_WIDTH, P_PACK} phase_t;

	state_t      state_q, n_state;
	job_t        job_q, n_job;
	phase_t      phase_q, n_phase;
	logic [31:0] vacc_q, n_vacc;
	logic [5:0]  vshift_q, n_vshift;
	logic [31:0] minb_q, n_minb;
	logic [5:0]  width_q, n_width;
	logic [39:0] buf_q, n_buf;
	logic [5:0]  fill_q, n_fill;
	logic [VW-1:0] vleft_q, n_vleft;
	logic [MW-1:0] mleft_q, n_mleft;
	logic        disc_q, n_disc;
	logic [31:0] data_q, n_data;
	logic [VW-1:0] cnt_q, n_cnt;
	logic        endclr_q, n_endclr;
	logic        clear;

	logic [7:0]  b;
	logic        lst;
	logic [39:0] vshifted;
	logic [31:0] acc_n;
	logic [5:0]  shift_n;
	logic [31:0] zz;
	logic [MW-1:0] mdec;
	logic [39:0] nbuf;
	logic [5:0]  nfill;
	logic [VW+5:0] need;
	logic        allfit;
	logic        fits_any;
	logic [39:0] mask;
	logic [5:0]  fill_rem;
	logic        stop;

	assign byte_ch.ready = (state_q == ST_IDLE);
	assign b   = byte_ch.data_byte;
	assign lst = byte_ch.last_byte;

	always_comb begin
		vshifted = {33'd0, b[6:0]} << vshift_q;
		acc_n    = vacc_q | ((vshift_q < 6'd32) ? vshifted[31:0] : 32'd0);
		shift_n  = (vshift_q > 6'd28) ? 6'd35 : (vshift_q + 6'd7);
		zz       = {1'b0, acc_n[31:1]} ^ {32{acc_n[0]}};
		mdec     = mleft_q - MW'(mleft_q != '0);
		nbuf     = buf_q | ({32'd0, b} << fill_q);
		nfill    = fill_q + 6'd8;
		need     = (VW + 6)'(vleft_q) * (VW + 6)'(width_q);
		allfit   = need <= (VW + 6)'(nfill);
		fits_any = nfill >= width_q;
		mask     = (40'd1 << width_q) - 40'd1;
		fill_rem = fill_q - width_q;
		stop     = (vleft_q == VW'(1)) || (fill_rem < width_q);
	end

	always_comb begin
		n_state  = state_q;
		n_job    = job_q;
		n_phase  = phase_q;
		n_vacc   = vacc_q;
		n_vshift = vshift_q;
		n_minb   = minb_q;
		n_width  = width_q;
		n_buf    = buf_q;
		n_fill   = fill_q;
		n_vleft  = vleft_q;
		n_mleft  = mleft_q;
		n_disc   = disc_q;
		n_data   = data_q;
		n_cnt    = cnt_q;
		n_endclr = endclr_q;
		clear    = 1'b0;
		push     = 1'b0;
		push_entry.kind     = dbpd_pkg::E_ADD;
		push_entry.data     = data_q;
		push_entry.run_last = 1'b1;

		case (state_q)
			ST_IDLE: begin
				if (byte_ch.valid) begin
					if (disc_q) begin
						clear = lst;
					end else begin
						case (phase_q)
							P_FIRST, P_MIN: begin
								if (b[7]) begin
									n_vacc   = acc_n;
									n_vshift = shift_n;
								end else begin
									n_vacc   = '0;
									n_vshift = '0;
									if (phase_q == P_FIRST) begin
										n_data  = zz;
										n_job   = J_SET;
										n_state = ST_RUN;
										n_phase = P_MIN;
									end else begin
										n_minb  = zz;
										n_mleft = MW'(MB);
										n_phase = P_WIDTH;
									end
								end
								if (lst) begin
									clear = 1'b1;
									if (b[7] || phase_q == P_MIN) begin
										n_job   = J_ERR;
										n_state = ST_RUN;
									end
								end
							end
							P_WIDTH: begin
								n_state = ST_RUN;
								if (b > 8'd32) begin
									n_job  = J_ERR;
									n_disc = !lst;
									clear  = lst;
								end else if (b == 8'd0) begin
									n_job   = J_ZERO;
									n_data  = minb_q;
									n_cnt   = VW'(MINI_SIZE);
									n_mleft = mdec;
									n_phase = (mdec != '0) ? P_WIDTH : P_MIN;
									if (lst) begin
										clear = 1'b1;
										if (mdec != '0) begin
											n_job = J_ERR;
										end
									end
								end else begin
									n_state = ST_IDLE;
									n_width = b[5:0];
									n_vleft = VW'(MINI_SIZE);
									n_buf   = '0;
									n_fill  = '0;
									n_phase = P_PACK;
									if (lst) begin
										n_job   = J_ERR;
										n_state = ST_RUN;
										clear   = 1'b1;
									end
								end
							end
							default: begin
								n_buf    = nbuf;
								n_fill   = nfill;
								n_job    = J_PACK;
								n_endclr = lst;
								if (lst) begin
									n_state = ST_RUN;
									if (!(allfit && mdec == '0)) begin
										n_job = J_ERR;
										clear = 1'b1;
									end
								end else if (fits_any) begin
									n_state = ST_RUN;
								end
							end
						endcase
					end
				end
			end
			default: begin
				if (!full) begin
					push = 1'b1;
					case (job_q)
						J_SET: begin
							push_entry.kind = dbpd_pkg::E_SET;
							n_state = ST_IDLE;
						end
						J_ERR: begin
							push_entry.kind = dbpd_pkg::E_ERR;
							n_state = ST_IDLE;
						end
						J_ZERO: begin
							push_entry.run_last = (cnt_q == VW'(1));
							n_cnt = cnt_q - VW'(1);
							if (cnt_q == VW'(1)) begin
								n_state = ST_IDLE;
							end
						end
						default: begin
							push_entry.data     = minb_q + (buf_q[31:0] & mask[31:0]);
							push_entry.run_last = stop;
							n_buf   = buf_q >> width_q;
							n_fill  = fill_rem;
							n_vleft = vleft_q - VW'(1);
							if (stop) begin
								n_state = ST_IDLE;
								if (vleft_q == VW'(1)) begin
									n_buf   = '0;
									n_fill  = '0;
									n_mleft = mdec;
									n_phase = (mdec != '0) ? P_WIDTH : P_MIN;
								end
								clear = endclr_q;
							end
						end
					endcase
				end
			end
		endcase

		if (clear) begin
			n_phase  = P_FIRST;
			n_vacc   = '0;
			n_vshift = '0;
			n_minb   = '0;
			n_width  = '0;
			n_buf    = '0;
			n_fill   = '0;
			n_vleft  = '0;
			n_mleft  = '0;
			n_disc   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			job_q    <= J_SET;
			phase_q  <= P_FIRST;
			vacc_q   <= '0;
			vshift_q <= '0;
			minb_q   <= '0;
			width_q  <= '0;
			buf_q    <= '0;
			fill_q   <= '0;
			vleft_q  <= '0;
			mleft_q  <= '0;
			disc_q   <= 1'b0;
			cnt_q    <= '0;
			endclr_q <= 1'b0;
		end else begin
			state_q  <= n_state;
			job_q    <= n_job;
			phase_q  <= n_phase;
			vacc_q   <= n_vacc;
			vshift_q <= n_vshift;
			minb_q   <= n_minb;
			width_q  <= n_width;
			buf_q    <= n_buf;
			fill_q   <= n_fill;
			vleft_q  <= n_vleft;
			mleft_q  <= n_mleft;
			disc_q   <= n_disc;
			cnt_q    <= n_cnt;
			endclr_q <= n_endclr;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= n_data;
	end

endmodule

// ===== src/dbpd_fifo.sv =====
// ----------------------------------------------------------------------------
// dbpd_fifo
// Short word queue between parser and value builder.
// ----------------------------------------------------------------------------
module dbpd_fifo #(
	parameter int unsigned DEPTH = dbpd_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dbpd_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output dbpd_pkg::entry_t head,
	output logic             empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	dbpd_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
		end
	end

endmodule

// ===== src/dbpd_back.sv =====
// ----------------------------------------------------------------------------
// dbpd_back
// Value builder: runs the accumulated value and drives the result register.
// ----------------------------------------------------------------------------
module dbpd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  dbpd_pkg::entry_t head,
	input  logic             empty,
	output logic             pop,
	dbpd_result_if.source    result_ch
);

	logic                         valid_q;
	logic [dbpd_pkg::VALUE_W-1:0] value_q;
	logic [dbpd_pkg::VALUE_W-1:0] prev_q;
	logic                         rl_q;
	logic                         err_q;
	logic [dbpd_pkg::VALUE_W-1:0] sum;

	assign pop                = !empty && (!valid_q || result_ch.ready);
	assign sum                = prev_q + head.data;
	assign result_ch.valid    = valid_q;
	assign result_ch.value    = value_q;
	assign result_ch.run_last = rl_q;
	assign result_ch.error    = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rl_q <= head.run_last;
			case (head.kind)
				dbpd_pkg::E_SET: begin
					value_q <= head.data;
					prev_q  <= head.data;
					err_q   <= 1'b0;
				end
				dbpd_pkg::E_ADD: begin
					value_q <= sum;
					prev_q  <= sum;
					err_q   <= 1'b0;
				end
				default: begin
					value_q <= '0;
					err_q   <= 1'b1;
				end
			endcase
		end
	end

endmodule

// ===== src/dbpd_checker.sv =====
// ----------------------------------------------------------------------------
// dbpd_checker
// Port-level checks of the delta block packed decoder.
// ----------------------------------------------------------------------------
module dbpd_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [dbpd_pkg::VALUE_W-1:0] value,
	input logic                                run_last,
	input logic                                error
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value) && $stable(run_last)
			&& $stable(error))
		else $error("result changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> value == '0)
		else $error("error result with nonzero value");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> run_last)
		else $error("error result not marked last");

endmodule

bind delta_block_packed_decoder dbpd_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(result_ch.valid),
	.out_ready(result_ch.ready),
	.value(result_ch.value),
	.run_last(result_ch.run_last),
	.error(result_ch.error)
);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Feeds encoded delta streams into delta_block_packed_decoder byte by byte.
// A short table of hand-picked bytes comes first, then random streams that
// are mostly well formed, some cut short, some with bad widths, some noise.
// Each result word is compared against an in-bench decoder model, or against a table row's expected word.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MINI_SIZE     = dbpd_pkg::MINI_SIZE_DEF;
	localparam int unsigned BLOCK_LEN     = dbpd_pkg::BLOCK_LEN_DEF;
	localparam int unsigned MINIS         = (BLOCK_LEN / MINI_SIZE == 0) ? 1 : BLOCK_LEN / MINI_SIZE;
	localparam int unsigned DIRECTED_ROWS = 25;
	localparam int unsigned RANDOM_BYTES  = 150;
	localparam int unsigned CALM_TAIL     = 40;
	localparam int unsigned DRAIN_CYCLES  = 32;
	localparam int unsigned LIMIT_CYCLES  = 600000;
	localparam int unsigned MAX_REPORTS   = 10;

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_MIN_DELTA,
		PH_WIDTH,
		PH_PACKED
	} dec_phase_t;

	typedef enum int unsigned {
		ST_CLEAN,
		ST_CUT,
		ST_BAD_WIDTH,
		ST_NOISE
	} stream_kind_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic        has_exp;
		logic [31:0] exp_value;
		logic        exp_error;
	} stim_t;

	typedef struct packed {
		logic [31:0] value;
		logic        run_last;
		logic        error;
	} dec_result_t;

	logic clk = 1'b0;
	logic arst_n;

	dbpd_byte_if   byte_bus ();
	dbpd_result_if result_bus ();

	delta_block_packed_decoder #(
		.MINI_SIZE(MINI_SIZE),
		.BLOCK_LEN(BLOCK_LEN)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_bus),
		.result_ch (result_bus)
	);

	always #1 clk = ~clk;

	stim_t directed_rows [DIRECTED_ROWS] = '{
		'{8'h00, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
		'{8'h02, 1'b0, 1'b0, 32'h0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 32'h0, 1'b0},
		'{8'h01, 1'b0, 1'b0, 32'h0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 32'h0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 32'h0, 1'b0},
		'{8'hA5, 1'b0, 1'b0, 32'h0, 1'b0},
		'{8'h5A, 1'b0, 1'b0, 32'h0, 1'b0},
		'{8'h21, 1'b0, 1'b1, 32'h0000_0000, 1'b1},
		'{8'h12, 1'b0, 1'b0, 32'h0, 1'b0},
		'{8'h34, 1'b1, 1'b0, 32'h0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 32'h0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 32'h0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 32'h0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 32'h0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 32'h0, 1'b0},
		'{8'h7F, 1'b0, 1'b1, 32'h8000_0000, 1'b0},
		'{8'hFE, 1'b0, 1'b0, 32'h0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 32'h0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 32'h0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 32'h0, 1'b0},
		'{8'h0F, 1'b0, 1'b0, 32'h0, 1'b0},
		'{8'h03, 1'b0, 1'b0, 32'h0, 1'b0},
		'{8'h07, 1'b1, 1'b1, 32'h0000_0000, 1'b1},
		'{8'h01, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0}
	};

	stim_t       byte_stream [$];
	stim_t       cur_item;
	dec_result_t pending_values [$];
	dec_result_t byte_results [$];
	int unsigned mismatch_cnt = 0;
	int unsigned cycle_cnt = 0;
	int unsigned stall_left = 0;
	bit          calm = 1'b0;

	dec_phase_t  ph;
	logic [31:0] acc;
	int unsigned shift;
	logic [31:0] prev_val;
	logic [31:0] min_delta;
	int unsigned width;
	logic [63:0] bitbuf;
	int unsigned fill;
	int unsigned vals_left;
	int unsigned minis_left;
	bit          discard;

	function automatic void model_reset();
		ph         = PH_FIRST;
		acc        = '0;
		shift      = 0;
		prev_val   = '0;
		min_delta  = '0;
		width      = 0;
		bitbuf     = '0;
		fill       = 0;
		vals_left  = 0;
		minis_left = 0;
		discard    = 1'b0;
	endfunction

	function automatic void add_result(input logic [31:0] v, input logic err);
		byte_results.push_back('{err ? 32'd0 : v, 1'b0, err});
	endfunction

	function automatic void close_miniblock();
		if (minis_left > 0)
			minis_left--;
		ph = (minis_left != 0) ? PH_WIDTH : PH_MIN_DELTA;
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic last);
		logic [63:0] wide;
		logic [63:0] mask;
		logic [63:0] d;
		logic [31:0] raw;
		logic [31:0] v;
		byte_results.delete();
		if (discard) begin
			if (last)
				model_reset();
			return;
		end
		case (ph)
			PH_FIRST, PH_MIN_DELTA: begin
				if (shift < 32) begin
					wide = 64'(b[6:0]) << shift;
					acc |= wide[31:0];
				end
				if (b[7]) begin
					shift = (shift + 7 > 35) ? 35 : shift + 7;
				end else begin
					raw   = acc;
					v     = (raw >> 1) ^ {32{raw[0]}};
					acc   = '0;
					shift = 0;
					if (ph == PH_FIRST) begin
						prev_val = v;
						add_result(v, 1'b0);
						ph = PH_MIN_DELTA;
					end else begin
						min_delta  = v;
						minis_left = MINIS;
						ph         = PH_WIDTH;
					end
				end
			end
			PH_WIDTH: begin
				if (b > 8'd32) begin
					add_result(32'd0, 1'b1);
					byte_results[0].run_last = 1'b1;
					if (last)
						model_reset();
					else
						discard = 1'b1;
					return;
				end
				if (b == 8'd0) begin
					repeat (MINI_SIZE) begin
						prev_val += min_delta;
						add_result(prev_val, 1'b0);
					end
					close_miniblock();
				end else begin
					width     = 32'(b);
					vals_left = MINI_SIZE;
					bitbuf    = '0;
					fill      = 0;
					ph        = PH_PACKED;
				end
			end
			PH_PACKED: begin
				mask = (64'd1 << width) - 64'd1;
				bitbuf |= 64'(b) << fill;
				fill += 8;
				while (vals_left != 0 && fill >= width) begin
					d = bitbuf & mask;
					bitbuf = bitbuf >> width;
					fill -= width;
					prev_val += min_delta + d[31:0];
					add_result(prev_val, 1'b0);
					vals_left--;
				end
				if (vals_left == 0) begin
					bitbuf = '0;
					fill   = 0;
					close_miniblock();
				end
			end
		endcase
		if (last) begin
			if (!(ph == PH_MIN_DELTA && shift == 0)) begin
				byte_results.delete();
				add_result(32'd0, 1'b1);
			end
			model_reset();
		end
		if (byte_results.size() > 0)
			byte_results[byte_results.size()-1].run_last = 1'b1;
	endfunction

	function automatic void note_failure(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_REPORTS)
			$display("%0t ns: %s", $time, msg);
	endfunction

	function automatic void push_byte(input logic [7:0] b, input logic last);
		byte_stream.push_back('{b, last, 1'b0, 32'd0, 1'b0});
	endfunction

	function automatic void push_varint(input logic [31:0] v, input int unsigned pad);
		logic [31:0] raw;
		raw = {v[30:0], 1'b0} ^ {32{v[31]}};
		while (raw > 32'h7F) begin
			push_byte({1'b1, raw[6:0]}, 1'b0);
			raw = raw >> 7;
		end
		repeat (pad) begin
			push_byte({1'b1, raw[6:0]}, 1'b0);
			raw = '0;
		end
		push_byte({1'b0, raw[6:0]}, 1'b0);
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3, 4: return 32'($urandom_range(0, 63)) - 32'd32;
			default: return $urandom();
		endcase
	endfunction

	function automatic int unsigned pick_pad();
		return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
	endfunction

	function automatic int unsigned pick_width();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return 0;
		if (r < 75)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 8);
		if (r < 99)
			return $urandom_range(9, 31);
		return 32;
	endfunction

	function automatic void push_stream();
		stream_kind_t kind;
		int unsigned  r;
		int unsigned  start;
		int unsigned  nblocks;
		int unsigned  bad_at;
		int unsigned  blk;
		int unsigned  mb;
		int unsigned  w;
		int unsigned  cut;
		bit           stop;
		r = $urandom_range(0, 9);
		kind = (r < 7) ? ST_CLEAN : (r == 7) ? ST_CUT : (r == 8) ? ST_BAD_WIDTH : ST_NOISE;
		start = byte_stream.size();
		stop = 1'b0;
		if (kind == ST_NOISE) begin
			repeat ($urandom_range(1, 6))
				push_byte(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			push_varint(pick_value(), pick_pad());
			nblocks = ($urandom_range(0, 3) == 0) ? 2 : 1;
			bad_at  = $urandom_range(0, nblocks * MINIS - 1);
			for (blk = 0; blk < nblocks && !stop; blk++) begin
				push_varint(pick_value(), pick_pad());
				for (mb = 0; mb < MINIS && !stop; mb++) begin
					if (kind == ST_BAD_WIDTH && blk * MINIS + mb == bad_at) begin
						push_byte(8'($urandom_range(33, 255)), 1'b0);
						repeat ($urandom_range(0, 4))
							push_byte(8'($urandom_range(0, 255)), 1'b0);
						stop = 1'b1;
					end else begin
						w = pick_width();
						push_byte(8'(w), 1'b0);
						repeat ((MINI_SIZE * w + 7) / 8)
							push_byte(8'($urandom_range(0, 255)), 1'b0);
					end
				end
			end
			if (kind == ST_CUT) begin
				cut = $urandom_range(start, byte_stream.size() - 1);
				while (byte_stream.size() > cut + 1)
					void'(byte_stream.pop_back());
			end
		end
		byte_stream[byte_stream.size()-1].last = 1'b1;
	endfunction

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("tb_top failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_bus.ready <= 1'b0;
		end else if (!calm && arst_n && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 12);
			result_bus.ready <= 1'b0;
		end else begin
			result_bus.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		dec_result_t got;
		dec_result_t want;
		if (byte_bus.valid && byte_bus.ready) begin
			decode_byte(byte_bus.data_byte, byte_bus.last_byte);
			if (cur_item.has_exp)
				pending_values.push_back('{cur_item.exp_value, 1'b1, cur_item.exp_error});
			else
				foreach (byte_results[i])
					pending_values.push_back(byte_results[i]);
		end
		if (result_bus.valid && result_bus.ready) begin
			got = '{result_bus.value, result_bus.run_last, result_bus.error};
			if (pending_values.size() == 0) begin
				note_failure($sformatf("unexpected word: value=%0d run_last=%0b error=%0b",
					$signed(got.value), got.run_last, got.error));
			end else begin
				want = pending_values.pop_front();
				if (got.value !== want.value || got.run_last !== want.run_last ||
				    got.error !== want.error)
					note_failure($sformatf({"word mismatch: expected value=%0d run_last=%0b ",
						"error=%0b, got value=%0d run_last=%0b error=%0b"},
						$signed(want.value), want.run_last, want.error,
						$signed(got.value), got.run_last, got.error));
			end
		end
	end

	initial begin
		stim_t item;
		arst_n              = 1'b0;
		byte_bus.valid      = 1'b0;
		byte_bus.data_byte  = 8'h00;
		byte_bus.last_byte  = 1'b0;
		result_bus.ready    = 1'b0;
		cur_item            = '0;
		model_reset();
		foreach (directed_rows[i])
			byte_stream.push_back(directed_rows[i]);
		while (byte_stream.size() < DIRECTED_ROWS + RANDOM_BYTES)
			push_stream();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		while (byte_stream.size() != 0) begin
			item = byte_stream.pop_front();
			calm = (byte_stream.size() < CALM_TAIL);
			if (!calm && $urandom_range(0, 3) == 0) begin
				byte_bus.valid <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			byte_bus.valid     <= 1'b1;
			byte_bus.data_byte <= item.data;
			byte_bus.last_byte <= item.last;
			cur_item           <= item;
			@(posedge clk);
			while (!byte_bus.ready) @(posedge clk);
		end
		byte_bus.valid <= 1'b0;
		@(posedge clk);

		while (pending_values.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending_values.size() != 0)
			note_failure($sformatf("%0d expected words never arrived", pending_values.size()));
		if (mismatch_cnt == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
